@@ rtl/iir_pkg.sv @@
package iir_pkg;

    localparam int MAX_FWD_TAPS = 16;
    localparam int MAX_FB_TAPS  = 16;

    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int VALUE_W   = 18;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int TAPS_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam int FWD_IDX_W = (MAX_FWD_TAPS > 1) ? $clog2(MAX_FWD_TAPS) : 1;
    localparam int FB_IDX_W  = (MAX_FB_TAPS > 1) ? $clog2(MAX_FB_TAPS) : 1;
    localparam int FWD_CNT_W = $clog2(MAX_FWD_TAPS + 1);
    localparam int FB_CNT_W  = $clog2(MAX_FB_TAPS + 1);
    localparam int TERM_W    = $clog2(MAX_FWD_TAPS + MAX_FB_TAPS);

    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = PROD_W + TERM_W + 1;
    localparam int QUO_W     = SAMPLE_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_B = 2'd0,
        FUNC_LOAD_A = 2'd1,
        FUNC_LOAD_Y = 2'd2,
        FUNC_SAMPLE = 2'd3
    } func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_B_TAPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_TAPS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_WB
    } ctrl_state_t;

    typedef struct packed {
        logic absorb;
        logic mac_clear;
        logic mac_issue;
        logic div_init;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run;
        logic mac_last;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [VALUE_W-1:0] v);
        logic signed [VALUE_W-1:0] hi;
        logic signed [VALUE_W-1:0] lo;
        logic [SAMPLE_W-1:0]       res;
        hi = VALUE_W'(2 ** (SAMPLE_W - 1) - 1);
        lo = ~hi;
        if (v > hi)
        begin
            res = hi[SAMPLE_W-1:0];
        end
        else if (v < lo)
        begin
            res = lo[SAMPLE_W-1:0];
        end
        else
        begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/iir_if.sv @@
interface iir_req_if import iir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [SLOT_W-1:0]          slot;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output func, output slot, output value, input ready);
    modport sink   (input valid, input func, input slot, input value, output ready);
endinterface

interface iir_rsp_if import iir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] y_out;
    logic                       saturated;
    logic                       zero_divisor;

    modport source (output valid, output y_out, output saturated, output zero_divisor,
                    input ready);
    modport sink   (input valid, input y_out, input saturated, input zero_divisor,
                    output ready);
endinterface

interface iir_cfg_if import iir_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TAPS_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/iir_direct_form_filter.sv @@
// channel  role    beat contents
// req      sink    func, slot, value: coefficient load, past output load or sample
// rsp      source  y_out, saturated, zero_divisor: one filtered sample
// cfg      sink    index, data: b_taps (index 0) or a_taps (index 1)
//
// one item at a time; a sample with a result runs through one shared multiplier,
// one tap a cycle, then a restoring divider, one quotient bit a cycle
// rsp has its own output register, so the next item is taken while a result waits
// a result stalls only when the previous one is still held on rsp
// reset clears taps to 1, coefficients and histories to zero
module iir_direct_form_filter import iir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    iir_req_if.sink   req,
    iir_rsp_if.source rsp,
    iir_cfg_if.sink   cfg
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    iir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    iir_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_func  (req.func),
        .req_slot  (req.slot),
        .req_value (req.value),
        .rsp       (rsp),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/iir_ctrl.sv @@
module iir_ctrl import iir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.absorb = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.run)
                begin
                    cmd.mac_clear = 1'b1;
                    state_next    = ST_MAC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (status.mac_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/iir_dp.sv @@
module iir_dp import iir_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [FUNC_W-1:0]         req_func,
    input  logic [SLOT_W-1:0]         req_slot,
    input  logic signed [VALUE_W-1:0] req_value,
    iir_rsp_if.source                 rsp,
    iir_cfg_if.sink                   cfg,
    input  ctrl_cmd_t                 cmd,
    output ctrl_status_t              status
);

    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(2 ** (SAMPLE_W - 1));
    localparam logic signed [SAMPLE_W-1:0] Y_MAX = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [SAMPLE_W-1:0] Y_MIN = ~Y_MAX;

    logic [TAPS_W-1:0] b_taps_reg;
    logic [TAPS_W-1:0] a_taps_reg;

    logic signed [SAMPLE_W-1:0] x_hist_reg [MAX_FWD_TAPS];
    logic signed [SAMPLE_W-1:0] y_hist_reg [MAX_FB_TAPS];
    logic signed [COEF_W-1:0]   b_coef_reg [MAX_FWD_TAPS];
    logic signed [COEF_W-1:0]   a_coef_reg [MAX_FB_TAPS];

    logic [FWD_CNT_W-1:0] primed_reg;
    logic                 sample_reg;

    logic [TERM_W-1:0]        term_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [ACC_W-1:0]     rem_reg;
    logic [COEF_W-1:0]    den_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                 neg_reg;
    logic                 ovf_reg;
    logic                 zdiv_reg;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       sat_reg;
    logic                       zd_reg;

    logic [FWD_CNT_W-1:0] nb;
    logic [FB_CNT_W-1:0]  na;
    logic                 fwd_term;
    logic [TERM_W-1:0]    fb_off;
    logic [TERM_W-1:0]    fb_coef_idx;
    logic signed [COEF_W-1:0]   coef_sel;
    logic signed [SAMPLE_W-1:0] hist_sel;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    prod_ext;

    logic [ACC_W-1:0]     acc_neg;
    logic [ACC_W-1:0]     acc_mag;
    logic signed [COEF_W-1:0] a0;
    logic [COEF_W-1:0]    den_mag;
    logic [ACC_W-1:0]     den_top;
    logic [ACC_W-1:0]     den_shift;
    logic                 div_ge;

    logic [QUO_W-1:0]           quo_neg;
    logic signed [SAMPLE_W-1:0] y_calc;
    logic                       sat_calc;
    logic [SAMPLE_W-1:0]        sat_value;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_taps_reg <= TAPS_W'(1);
            a_taps_reg <= TAPS_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_B_TAPS: b_taps_reg <= cfg.data;
                CFG_A_TAPS: a_taps_reg <= cfg.data;
                default:    b_taps_reg <= b_taps_reg;
            endcase
        end
    end

    always_comb
    begin
        if (b_taps_reg == '0)
        begin
            nb = FWD_CNT_W'(1);
        end
        else if (int'(b_taps_reg) > MAX_FWD_TAPS)
        begin
            nb = FWD_CNT_W'(MAX_FWD_TAPS);
        end
        else
        begin
            nb = FWD_CNT_W'(b_taps_reg);
        end
        if (a_taps_reg == '0)
        begin
            na = FB_CNT_W'(1);
        end
        else if (int'(a_taps_reg) > MAX_FB_TAPS)
        begin
            na = FB_CNT_W'(MAX_FB_TAPS);
        end
        else
        begin
            na = FB_CNT_W'(a_taps_reg);
        end
    end

    assign sat_value = sat_sample(req_value);

    // multiply-accumulate term select
    assign fwd_term    = int'(term_reg) < int'(nb);
    assign fb_off      = term_reg - TERM_W'(nb);
    assign fb_coef_idx = fb_off + TERM_W'(1);
    assign coef_sel    = fwd_term ? b_coef_reg[term_reg[FWD_IDX_W-1:0]]
                                  : a_coef_reg[fb_coef_idx[FB_IDX_W-1:0]];
    assign hist_sel    = fwd_term ? x_hist_reg[term_reg[FWD_IDX_W-1:0]]
                                  : y_hist_reg[fb_off[FB_IDX_W-1:0]];
    assign prod_next   = coef_sel * hist_sel;
    assign prod_ext    = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // divider setup
    assign acc_neg   = -acc_reg;
    assign acc_mag   = acc_reg[ACC_W-1] ? acc_neg : acc_reg;
    assign a0        = a_coef_reg[0];
    assign den_mag   = a0[COEF_W-1] ? -a0 : a0;
    assign den_top   = ACC_W'(den_mag) << QUO_W;
    assign den_shift = ACC_W'(den_reg) << dcnt_reg;
    assign div_ge    = rem_reg >= den_shift;

    // quotient to sample with saturation
    assign quo_neg = -quo_reg;
    always_comb
    begin
        y_calc   = '0;
        sat_calc = 1'b0;
        if (zdiv_reg)
        begin
            y_calc   = '0;
            sat_calc = 1'b0;
        end
        else if (neg_reg)
        begin
            if (ovf_reg || quo_reg > NEG_LIMIT)
            begin
                y_calc   = Y_MIN;
                sat_calc = 1'b1;
            end
            else
            begin
                y_calc = quo_neg[SAMPLE_W-1:0];
            end
        end
        else
        begin
            if (ovf_reg || quo_reg > POS_LIMIT)
            begin
                y_calc   = Y_MAX;
                sat_calc = 1'b1;
            end
            else
            begin
                y_calc = quo_reg[SAMPLE_W-1:0];
            end
        end
    end

    // coefficient and history storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FWD_TAPS; i++)
            begin
                x_hist_reg[i] <= '0;
                b_coef_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_FB_TAPS; i++)
            begin
                y_hist_reg[i] <= '0;
                a_coef_reg[i] <= '0;
            end
            primed_reg <= '0;
            sample_reg <= 1'b0;
        end
        else if (cmd.absorb)
        begin
            sample_reg <= (req_func == FUNC_SAMPLE);
            unique case (req_func)
                FUNC_LOAD_B:
                begin
                    if (int'(req_slot) < MAX_FWD_TAPS)
                    begin
                        b_coef_reg[FWD_IDX_W'(req_slot)] <= req_value;
                    end
                end
                FUNC_LOAD_A:
                begin
                    if (int'(req_slot) < MAX_FB_TAPS)
                    begin
                        a_coef_reg[FB_IDX_W'(req_slot)] <= req_value;
                    end
                end
                FUNC_LOAD_Y:
                begin
                    if (int'(req_slot) < MAX_FB_TAPS)
                    begin
                        y_hist_reg[FB_IDX_W'(req_slot)] <= sat_value;
                    end
                    primed_reg <= '0;
                end
                FUNC_SAMPLE:
                begin
                    for (int i = MAX_FWD_TAPS - 1; i > 0; i--)
                    begin
                        x_hist_reg[i] <= x_hist_reg[i-1];
                    end
                    x_hist_reg[0] <= sat_value;
                    if (int'(primed_reg) < MAX_FWD_TAPS)
                    begin
                        primed_reg <= primed_reg + FWD_CNT_W'(1);
                    end
                end
                default:
                begin
                    primed_reg <= primed_reg;
                end
            endcase
        end
        else if (cmd.out_load)
        begin
            for (int i = MAX_FB_TAPS - 1; i > 0; i--)
            begin
                y_hist_reg[i] <= y_hist_reg[i-1];
            end
            y_hist_reg[0] <= y_calc;
        end
    end

    // multiply-accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg     <= '0;
            prod_vld_reg <= 1'b0;
        end
        else if (cmd.mac_clear)
        begin
            term_reg     <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mac_issue;
            if (cmd.mac_issue)
            begin
                term_reg <= term_reg + TERM_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_issue)
        begin
            prod_reg     <= prod_next;
            prod_sub_reg <= !fwd_term;
        end
        if (cmd.mac_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= prod_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            dcnt_reg <= DIV_CNT_W'(QUO_W - 1);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= acc_mag;
            den_reg  <= den_mag;
            quo_reg  <= '0;
            neg_reg  <= acc_reg[ACC_W-1] ^ a0[COEF_W-1];
            ovf_reg  <= acc_mag >= den_top;
            zdiv_reg <= (a0 == '0);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - den_shift;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
        end
    end

    // output register
    always_comb
    begin
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            y_reg   <= y_calc;
            sat_reg <= sat_calc;
            zd_reg  <= zdiv_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.y_out        = y_reg;
    assign rsp.saturated    = sat_reg;
    assign rsp.zero_divisor = zd_reg;

    assign status.run      = sample_reg && (int'(primed_reg) >= int'(nb));
    assign status.mac_last = int'(term_reg) == (int'(nb) + int'(na) - 2);
    assign status.div_last = (dcnt_reg == '0);
    assign status.out_free = !rsp_valid_reg || rsp.ready;

endmodule

@@ rtl/iir_checker.sv @@
module iir_checker import iir_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic signed [SAMPLE_W-1:0] y_out,
    input logic                       saturated,
    input logic                       zero_divisor
);

    localparam logic signed [SAMPLE_W-1:0] Y_MAX = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [SAMPLE_W-1:0] Y_MIN = ~Y_MAX;

    // zero divisor beat carries a clean zero
    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zero_divisor |-> (y_out == '0) && !saturated)
        else $error("zero divisor beat with nonzero output");

    // clipped beat sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && saturated |-> (y_out == Y_MAX) || (y_out == Y_MIN))
        else $error("saturated beat off the rails");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken on back-to-back cycles");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(y_out)
            && $stable(saturated) && $stable(zero_divisor))
        else $error("stalled rsp beat changed");

endmodule

bind iir_direct_form_filter iir_checker u_iir_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .y_out        (rsp.y_out),
    .saturated    (rsp.saturated),
    .zero_divisor (rsp.zero_divisor)
);

@@ verif/iir_direct_form_filter_test.sv @@
module iir_direct_form_filter_test;
    import iir_pkg::*;

    localparam int ITEMS       = 1550;
    localparam int SETTLE      = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRESSURE_AT = 1300;

    typedef struct {
        logic signed [SAMPLE_W-1:0] y;
        logic                       sat;
        logic                       zdiv;
    } filt_out_t;

    typedef struct {
        func_t             f;
        logic [SLOT_W-1:0] slot;
        int                value;
        bit                fixed;
        filt_out_t         want;
    } step_row_t;

    logic clk;
    logic rst_n;

    iir_req_if req_ch ();
    iir_rsp_if rsp_ch ();
    iir_cfg_if cfg_ch ();

    iir_direct_form_filter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // filter state as seen from outside
    logic signed [SAMPLE_W-1:0] x_hist [MAX_FWD_TAPS];
    logic signed [SAMPLE_W-1:0] y_hist [MAX_FB_TAPS];
    logic signed [COEF_W-1:0]   b_coef [MAX_FWD_TAPS];
    logic signed [COEF_W-1:0]   a_coef [MAX_FB_TAPS];
    int                         primed;
    logic [TAPS_W-1:0]          b_taps;
    logic [TAPS_W-1:0]          a_taps;

    filt_out_t pending_y [$];
    step_row_t dir_rows [0:21];

    int  errors;
    int  items;
    int  send_idle;
    int  recv_idle;
    int  stall_cycles;
    int  hold_cnt;
    bit  hold_req;

    always #5 clk = ~clk;

    function automatic int clamp_taps(input logic [TAPS_W-1:0] t, input int maxv);
        if (t < 1)
        begin
            return 1;
        end
        if (t > maxv)
        begin
            return maxv;
        end
        return int'(t);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v, output bit hit);
        hit = 1'b1;
        if (v > 32767)
        begin
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        hit = 1'b0;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic bit filter_step(input func_t f, input logic [SLOT_W-1:0] s,
                                       input logic signed [VALUE_W-1:0] v,
                                       output filt_out_t r);
        longint acc;
        int     nb;
        int     na;
        bit     hit;
        r.y    = '0;
        r.sat  = 1'b0;
        r.zdiv = 1'b0;
        acc    = 0;
        case (f)
            FUNC_LOAD_B:
            begin
                b_coef[s] = v;
                return 1'b0;
            end
            FUNC_LOAD_A:
            begin
                a_coef[s] = v;
                return 1'b0;
            end
            FUNC_LOAD_Y:
            begin
                y_hist[s] = clip16(longint'(v), hit);
                primed = 0;
                return 1'b0;
            end
            default:
            begin
            end
        endcase
        for (int i = MAX_FWD_TAPS - 1; i > 0; i--)
        begin
            x_hist[i] = x_hist[i-1];
        end
        x_hist[0] = clip16(longint'(v), hit);
        if (primed < MAX_FWD_TAPS)
        begin
            primed++;
        end
        nb = clamp_taps(b_taps, MAX_FWD_TAPS);
        na = clamp_taps(a_taps, MAX_FB_TAPS);
        if (primed < nb)
        begin
            return 1'b0;
        end
        for (int j = 0; j < nb; j++)
        begin
            acc += longint'(b_coef[j]) * longint'(x_hist[j]);
        end
        for (int j = 1; j < na; j++)
        begin
            acc -= longint'(a_coef[j]) * longint'(y_hist[j-1]);
        end
        if (a_coef[0] == 0)
        begin
            r.zdiv = 1'b1;
        end
        else
        begin
            r.y   = clip16(acc / longint'(a_coef[0]), hit);
            r.sat = hit;
        end
        for (int i = MAX_FB_TAPS - 1; i > 0; i--)
        begin
            y_hist[i] = y_hist[i-1];
        end
        y_hist[0] = r.y;
        return 1'b1;
    endfunction

    function automatic int rand_signed(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int pick_sample();
        if ($urandom_range(7) == 0)
        begin
            return int'($urandom_range(262143)) - 131072;
        end
        return rand_signed(24000);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (beat %0d pending)",
                 what, got, want, pending_y.size());
        errors++;
    endtask

    task automatic send_item(input func_t f, input logic [SLOT_W-1:0] s, input int v,
                             input bit fixed, input filt_out_t want);
        filt_out_t r;
        bit        has;
        if ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.slot  <= s;
        req_ch.value <= VALUE_W'(v);
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        has = filter_step(f, s, VALUE_W'(v), r);
        if (fixed)
        begin
            pending_y.push_back(want);
        end
        else if (has)
        begin
            pending_y.push_back(r);
        end
        items++;
        if (items < ITEMS / 3)
        begin
            send_idle = 38;
            recv_idle = 71;
        end
        else if (items < 2 * ITEMS / 3)
        begin
            send_idle = 71;
            recv_idle = 38;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (items == PRESSURE_AT)
        begin
            hold_req = 1'b1;
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_y.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_taps(input logic [TAPS_W-1:0] nb, input logic [TAPS_W-1:0] na);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_B_TAPS;
        cfg_ch.data  <= nb;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        b_taps = nb;
        cfg_ch.index <= CFG_A_TAPS;
        cfg_ch.data  <= na;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        a_taps = na;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [TAPS_W-1:0] nb_cfg, input logic [TAPS_W-1:0] na_cfg);
        filt_out_t none;
        int        nb;
        int        na;
        int        style;
        int        v;
        int        n;
        none  = '{y: '0, sat: 1'b0, zdiv: 1'b0};
        drain();
        set_taps(nb_cfg, na_cfg);
        nb    = clamp_taps(nb_cfg, MAX_FWD_TAPS);
        na    = clamp_taps(na_cfg, MAX_FB_TAPS);
        style = $urandom_range(9);
        for (int j = 0; j < MAX_FWD_TAPS; j++)
        begin
            if (j < nb || $urandom_range(3) == 0)
            begin
                v = (style == 0) ? int'($urandom_range(262143)) - 131072
                                 : rand_signed(16384 / nb);
                send_item(FUNC_LOAD_B, SLOT_W'(j), v, 1'b0, none);
            end
        end
        for (int j = 0; j < MAX_FB_TAPS; j++)
        begin
            if (j < na || $urandom_range(3) == 0)
            begin
                if (style == 0)
                begin
                    v = int'($urandom_range(262143)) - 131072;
                end
                else if (j == 0)
                begin
                    if (style == 1)
                    begin
                        v = 0;
                    end
                    else if ($urandom_range(1) == 0)
                    begin
                        v = 16384;
                    end
                    else
                    begin
                        v = int'($urandom_range(8192, 32767));
                        v = $urandom_range(1) ? v : -v;
                    end
                end
                else
                begin
                    v = rand_signed(8192 / na);
                end
                send_item(FUNC_LOAD_A, SLOT_W'(j), v, 1'b0, none);
            end
        end
        // seed some past outputs, which also restarts priming
        if ($urandom_range(1) == 0)
        begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
            begin
                send_item(FUNC_LOAD_Y, SLOT_W'($urandom_range(15)), pick_sample(), 1'b0, none);
            end
        end
        n = $urandom_range(20, 60);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(11) == 0)
            begin
                send_item(func_t'($urandom_range(3)), SLOT_W'($urandom_range(15)),
                          int'($urandom_range(262143)) - 131072, 1'b0, none);
            end
            else
            begin
                send_item(FUNC_SAMPLE, SLOT_W'($urandom_range(15)), pick_sample(), 1'b0, none);
            end
        end
    endtask

    // response side: check each beat, then pick ready for the next cycle
    always @(posedge clk)
    begin
        filt_out_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_y.size() == 0)
            begin
                report_mismatch("unexpected result y_out", int'(rsp_ch.y_out), 0);
            end
            else
            begin
                want = pending_y.pop_front();
                if (rsp_ch.y_out !== want.y)
                begin
                    report_mismatch("y_out", int'(rsp_ch.y_out), int'(want.y));
                end
                if (rsp_ch.saturated !== want.sat)
                begin
                    report_mismatch("saturated", int'(rsp_ch.saturated), int'(want.sat));
                end
                if (rsp_ch.zero_divisor !== want.zdiv)
                begin
                    report_mismatch("zero_divisor", int'(rsp_ch.zero_divisor),
                                    int'(want.zdiv));
                end
            end
        end
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no beat for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [TAPS_W-1:0] ext_b [7];
        logic [TAPS_W-1:0] ext_a [7];
        int                ph;

        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_LOAD_B;
        req_ch.slot  = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_B_TAPS;
        cfg_ch.data  = '0;
        errors       = 0;
        items        = 0;
        send_idle    = 38;
        recv_idle    = 71;
        stall_cycles = 0;
        hold_cnt     = 0;
        hold_req     = 1'b0;
        primed       = 0;
        b_taps       = 1;
        a_taps       = 1;
        for (int i = 0; i < MAX_FWD_TAPS; i++)
        begin
            x_hist[i] = '0;
            b_coef[i] = '0;
        end
        for (int i = 0; i < MAX_FB_TAPS; i++)
        begin
            y_hist[i] = '0;
            a_coef[i] = '0;
        end

        // taps stay at their reset value of one for the table
        dir_rows = '{
            '{FUNC_SAMPLE, 4'd0,  100,     1'b1, '{16'sd0,      1'b0, 1'b1}},
            '{FUNC_LOAD_A, 4'd0,  16384,   1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  5,       1'b1, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_LOAD_B, 4'd0,  16384,   1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  32767,   1'b1, '{16'sh7fff,   1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  -32768,  1'b1, '{16'sh8000,   1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  131071,  1'b1, '{16'sh7fff,   1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  -131072, 1'b1, '{16'sh8000,   1'b0, 1'b0}},
            '{FUNC_LOAD_A, 4'd0,  1,       1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  100,     1'b1, '{16'sh7fff,   1'b1, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  -100,    1'b1, '{16'sh8000,   1'b1, 1'b0}},
            '{FUNC_LOAD_A, 4'd0,  -131072, 1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  32767,   1'b1, '{-16'sd4095,  1'b0, 1'b0}},
            '{FUNC_LOAD_B, 4'd0,  131071,  1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd0,  -32768,  1'b1, '{16'sh7fff,   1'b0, 1'b0}},
            '{FUNC_LOAD_B, 4'd15, -1,      1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_LOAD_A, 4'd15, 131071,  1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_LOAD_Y, 4'd15, 131071,  1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_LOAD_Y, 4'd0,  -131072, 1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd3,  7,       1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_LOAD_B, 4'd1,  16384,   1'b0, '{16'sd0,      1'b0, 1'b0}},
            '{FUNC_SAMPLE, 4'd9,  -7,      1'b0, '{16'sd0,      1'b0, 1'b0}}
        };

        ext_b = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd16, 5'd1, 5'd2};
        ext_a = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd1, 5'd16, 5'd3};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].f, dir_rows[i].slot, dir_rows[i].value,
                      dir_rows[i].fixed, dir_rows[i].want);
        end

        ph = 0;
        while (items < ITEMS)
        begin
            if (ph < 7)
            begin
                run_phase(ext_b[ph], ext_a[ph]);
            end
            else
            begin
                run_phase(TAPS_W'($urandom_range(31)), TAPS_W'($urandom_range(31)));
            end
            ph++;
        end

        drain();
        while (pending_y.size() != 0)
        begin
            report_mismatch("missing result y_out", 0, int'(pending_y[0].y));
            void'(pending_y.pop_front());
        end
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
